// ===== rtl/virtual_joystick_axis_mapper_macros.svh =====
// Assertion macros used by the checker file of the joystick mapper.
`ifndef VIRTUAL_JOYSTICK_AXIS_MAPPER_MACROS_SVH
`define VIRTUAL_JOYSTICK_AXIS_MAPPER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VJAM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VJAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vjam_pkg.sv =====
package vjam_pkg;

  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_MOVE  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_RADIUS   = 2'd2;
  localparam logic [1:0] REG_DEADZONE = 2'd3;

  localparam logic [4:0] SQRT_STEPS = 5'd26;
  localparam logic [4:0] DIV_STEPS  = 5'd20;

  localparam logic [4:0] STEP_DIRECT = 5'd18;
  localparam logic [4:0] STEP_SIMPLE = 5'd22;
  localparam logic [4:0] STEP_FINISH = 5'd23;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } arith_cmd_t;

  typedef struct packed {
    logic busy;
  } arith_sts_t;

  typedef enum logic [1:0] {M_SX, M_SY, M_R} mul_sel_t;

  typedef enum logic [2:0] {N_SQ, N_PXR, N_PYR, N_CX, N_CY, N_SX, N_SY} num_sel_t;

  typedef enum logic {D_LEN, D_R} den_sel_t;

  typedef enum logic [1:0] {C_NONE, C_ALWAYS, C_NOT_MOVE, C_NO_CLAMP} cond_t;

  typedef enum logic [3:0] {
    A_NONE, A_SUM, A_SQ_SET, A_SQ_ADD, A_RSQ, A_PXR, A_PYR, A_LEN,
    A_CX, A_CY, A_AX, A_AY, A_KNOB_CLAMP, A_KNOB_DIRECT, A_SIMPLE, A_OUT
  } act_t;

  typedef struct packed {
    mul_sel_t   mul_a;
    mul_sel_t   mul_b;
    act_t       act;
    logic       start;
    logic       sqrt_mode;
    num_sel_t   num_sel;
    den_sel_t   den_sel;
    logic       hold_busy;
    cond_t      cond;
    logic [4:0] target;
    logic       last;
  } ucode_t;

  typedef struct packed {
    logic        neg;
    logic        pos;
    logic [15:0] strength;
  } dir_t;

  localparam ucode_t UC_NOP = '{
    mul_a: M_SX, mul_b: M_SX, act: A_NONE, start: 1'b0, sqrt_mode: 1'b0,
    num_sel: N_SQ, den_sel: D_LEN, hold_busy: 1'b0, cond: C_NONE,
    target: 5'd0, last: 1'b0
  };

  function automatic ucode_t ucode_rom(input logic [4:0] pc);
    ucode_t uc;
    uc = UC_NOP;
    case (pc)
      5'd0: begin
        uc.act = A_SUM; uc.cond = C_NOT_MOVE; uc.target = STEP_SIMPLE;
      end
      5'd1: begin
        uc.mul_a = M_SX; uc.mul_b = M_SX;
      end
      5'd2: begin
        uc.mul_a = M_SY; uc.mul_b = M_SY; uc.act = A_SQ_SET;
      end
      5'd3: begin
        uc.mul_a = M_R; uc.mul_b = M_R; uc.act = A_SQ_ADD;
      end
      5'd4: begin
        uc.mul_a = M_SX; uc.mul_b = M_R; uc.act = A_RSQ;
      end
      5'd5: begin
        uc.mul_a = M_SY; uc.mul_b = M_R; uc.act = A_PXR;
      end
      5'd6: begin
        uc.act = A_PYR; uc.cond = C_NO_CLAMP; uc.target = STEP_DIRECT;
      end
      5'd7: begin
        uc.start = 1'b1; uc.sqrt_mode = 1'b1; uc.num_sel = N_SQ;
      end
      5'd8: begin
        uc.hold_busy = 1'b1; uc.act = A_LEN;
      end
      5'd9: begin
        uc.start = 1'b1; uc.num_sel = N_PXR; uc.den_sel = D_LEN;
      end
      5'd10: begin
        uc.hold_busy = 1'b1; uc.act = A_CX;
      end
      5'd11: begin
        uc.start = 1'b1; uc.num_sel = N_PYR; uc.den_sel = D_LEN;
      end
      5'd12: begin
        uc.hold_busy = 1'b1; uc.act = A_CY;
      end
      5'd13: begin
        uc.start = 1'b1; uc.num_sel = N_CX; uc.den_sel = D_R;
      end
      5'd14: begin
        uc.hold_busy = 1'b1; uc.act = A_AX;
      end
      5'd15: begin
        uc.start = 1'b1; uc.num_sel = N_CY; uc.den_sel = D_R;
      end
      5'd16: begin
        uc.hold_busy = 1'b1; uc.act = A_AY;
      end
      5'd17: begin
        uc.act = A_KNOB_CLAMP; uc.cond = C_ALWAYS; uc.target = STEP_FINISH;
      end
      5'd18: begin
        uc.start = 1'b1; uc.num_sel = N_SX; uc.den_sel = D_R; uc.act = A_KNOB_DIRECT;
      end
      5'd19: begin
        uc.hold_busy = 1'b1; uc.act = A_AX;
      end
      5'd20: begin
        uc.start = 1'b1; uc.num_sel = N_SY; uc.den_sel = D_R;
      end
      5'd21: begin
        uc.hold_busy = 1'b1; uc.act = A_AY; uc.cond = C_ALWAYS; uc.target = STEP_FINISH;
      end
      5'd22: begin
        uc.act = A_SIMPLE;
      end
      5'd23: begin
        uc.act = A_OUT; uc.last = 1'b1;
      end
      default: begin
        uc.cond = C_ALWAYS; uc.target = STEP_FINISH;
      end
    endcase
    return uc;
  endfunction

  function automatic logic signed [15:0] sat_s16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic dir_t axis_dir(input logic signed [16:0] axis, input logic [15:0] dz);
    logic [16:0] mag;
    dir_t        d;
    mag = axis[16] ? 17'(-axis) : 17'(axis);
    if (mag < {1'b0, dz}) begin
      d = '0;
    end else begin
      d.neg      = axis[16];
      d.pos      = !axis[16] && (axis != 17'sd0);
      d.strength = mag[15:0];
    end
    return d;
  endfunction

endpackage

// ===== rtl/vjam_arith.sv =====
module vjam_arith (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vjam_pkg::arith_cmd_t cmd,
  input  logic [51:0]          num,
  input  logic [25:0]          den,
  output vjam_pkg::arith_sts_t sts,
  output logic [25:0]          q
);
  import vjam_pkg::*;

  logic        busy_r;
  logic [4:0]  count_r;
  logic        sqrt_r;
  logic [28:0] rem_r;
  logic [51:0] src_r;
  logic [25:0] q_r;
  logic [25:0] den_r;

  logic [28:0] trial_a;
  logic [28:0] trial_b;
  logic [29:0] diff;
  logic        ge;

  // One restoring step: two radicand bits per step for the root, one dividend bit
  // per step for the quotient.
  always_comb begin
    if (sqrt_r) begin
      trial_a = {rem_r[26:0], src_r[51:50]};
      trial_b = {1'b0, q_r, 2'b01};
    end else begin
      trial_a = {rem_r[27:0], src_r[51]};
      trial_b = {3'b000, den_r};
    end
    diff = {1'b0, trial_a} - {1'b0, trial_b};
    ge   = !diff[29];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      count_r <= 5'd0;
    end else if (cmd.start) begin
      busy_r  <= 1'b1;
      count_r <= cmd.sqrt_mode ? SQRT_STEPS : DIV_STEPS;
    end else if (busy_r) begin
      count_r <= count_r - 5'd1;
      if (count_r == 5'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sqrt_r <= cmd.sqrt_mode;
      den_r  <= den;
      q_r    <= 26'd0;
      if (cmd.sqrt_mode) begin
        rem_r <= 29'd0;
        src_r <= num;
      end else begin
        rem_r <= num[48:20];
        src_r <= {num[19:0], 32'd0};
      end
    end else if (busy_r) begin
      rem_r <= ge ? diff[28:0] : trial_a;
      q_r   <= {q_r[24:0], ge};
      src_r <= sqrt_r ? {src_r[49:0], 2'b00} : {src_r[50:0], 1'b0};
    end
  end

  assign sts.busy = busy_r;
  assign q        = q_r;

endmodule

// ===== rtl/virtual_joystick_axis_mapper.sv =====
// Begin, end and undefined operations skip the arithmetic; a move runs on the shared
// shift-and-subtract unit (26 steps for the square root, 20 steps for each of up to four
// divisions), so a clamped move takes longer than a move inside the radius.
// A new transaction is taken only after the previous one retires, so the block works
// on one event at a time.
// Synchronous active-low reset loads the register defaults and zeroes knob, offset and axes.
module virtual_joystick_axis_mapper (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic signed [15:0] in_touch_x,
  input  logic signed [15:0] in_touch_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_knob_x,
  output logic signed [15:0] out_knob_y,
  output logic signed [16:0] out_axis_x,
  output logic signed [16:0] out_axis_y,
  output logic               out_left_on,
  output logic               out_right_on,
  output logic               out_forward_on,
  output logic               out_back_on,
  output logic [15:0]        out_horizontal_strength,
  output logic [15:0]        out_vertical_strength,
  input  logic               cfg_write_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import vjam_pkg::*;

  logic        running_r;
  logic [4:0]  pc_r;
  logic        out_valid_r;

  logic [14:0] center_x_r;
  logic [14:0] center_y_r;
  logic [15:0] radius_r;
  logic [15:0] deadzone_r;

  logic signed [15:0] knob_x_r;
  logic signed [15:0] knob_y_r;
  logic signed [16:0] grab_x_r;
  logic signed [16:0] grab_y_r;
  logic signed [16:0] axis_x_r;
  logic signed [16:0] axis_y_r;

  logic [1:0]         op_r;
  logic signed [15:0] tx_r;
  logic signed [15:0] ty_r;
  logic signed [17:0] sx_r;
  logic signed [17:0] sy_r;
  logic [33:0]        prod_r;
  logic [34:0]        sq_r;
  logic [31:0]        rsq_r;
  logic [32:0]        pxr_r;
  logic [32:0]        pyr_r;
  logic [25:0]        len_r;
  logic signed [20:0] cx_r;
  logic signed [20:0] cy_r;

  logic signed [15:0] out_knob_x_r;
  logic signed [15:0] out_knob_y_r;
  logic signed [16:0] out_axis_x_r;
  logic signed [16:0] out_axis_y_r;
  dir_t               out_dir_x_r;
  dir_t               out_dir_y_r;

  ucode_t     uc;
  logic       stall;
  logic       advance;
  logic       jump;
  logic       clamp;
  logic [15:0] r16;

  logic signed [17:0] px_x;
  logic signed [17:0] px_y;
  logic signed [17:0] sx_calc;
  logic signed [17:0] sy_calc;
  logic signed [17:0] sx_neg;
  logic signed [17:0] sy_neg;
  logic [16:0]        sx_mag;
  logic [16:0]        sy_mag;
  logic signed [20:0] cx_neg;
  logic signed [20:0] cy_neg;
  logic [19:0]        cx_mag;
  logic [19:0]        cy_mag;
  logic [16:0]        mul_a_op;
  logic [16:0]        mul_b_op;

  logic signed [24:0] kvx;
  logic signed [24:0] kvy;
  logic signed [24:0] kvx_adj;
  logic signed [24:0] kvy_adj;
  logic signed [16:0] kx_clamp;
  logic signed [16:0] ky_clamp;

  logic [16:0]        q17;
  logic [20:0]        q21;

  arith_cmd_t  arith_cmd;
  arith_sts_t  arith_sts;
  logic [51:0] arith_num;
  logic [25:0] arith_den;
  logic [25:0] arith_q;

  assign uc = ucode_rom(pc_r);
  assign r16 = (radius_r == 16'd0) ? 16'd1 : radius_r;

  assign px_x    = {{2{tx_r[15]}}, tx_r} + {grab_x_r[16], grab_x_r};
  assign px_y    = {{2{ty_r[15]}}, ty_r} + {grab_y_r[16], grab_y_r};
  assign sx_calc = px_x - {3'b000, center_x_r};
  assign sy_calc = px_y - {3'b000, center_y_r};

  assign sx_neg = -sx_r;
  assign sy_neg = -sy_r;
  assign sx_mag = sx_r[17] ? sx_neg[16:0] : sx_r[16:0];
  assign sy_mag = sy_r[17] ? sy_neg[16:0] : sy_r[16:0];
  assign cx_neg = -cx_r;
  assign cy_neg = -cy_r;
  assign cx_mag = cx_r[20] ? cx_neg[19:0] : cx_r[19:0];
  assign cy_mag = cy_r[20] ? cy_neg[19:0] : cy_r[19:0];

  assign clamp = {sq_r, 8'd0} > {11'd0, rsq_r};

  // The clamped knob is the center plus the clamped offset, truncated toward zero.
  assign kvx      = {2'b00, center_x_r, 8'd0} + {{4{cx_r[20]}}, cx_r};
  assign kvy      = {2'b00, center_y_r, 8'd0} + {{4{cy_r[20]}}, cy_r};
  assign kvx_adj  = kvx + (kvx[24] ? 25'sd255 : 25'sd0);
  assign kvy_adj  = kvy + (kvy[24] ? 25'sd255 : 25'sd0);
  assign kx_clamp = kvx_adj[24:8];
  assign ky_clamp = kvy_adj[24:8];

  assign q17 = arith_q[16:0];
  assign q21 = {1'b0, arith_q[19:0]};

  always_comb begin
    case (uc.mul_a)
      M_SX:    mul_a_op = sx_mag;
      M_SY:    mul_a_op = sy_mag;
      M_R:     mul_a_op = {1'b0, r16};
      default: mul_a_op = 17'd0;
    endcase
    case (uc.mul_b)
      M_SX:    mul_b_op = sx_mag;
      M_SY:    mul_b_op = sy_mag;
      M_R:     mul_b_op = {1'b0, r16};
      default: mul_b_op = 17'd0;
    endcase
  end

  always_comb begin
    case (uc.num_sel)
      N_SQ:    arith_num = {1'b0, sq_r, 16'd0};
      N_PXR:   arith_num = {7'd0, pxr_r, 12'd0};
      N_PYR:   arith_num = {7'd0, pyr_r, 12'd0};
      N_CX:    arith_num = {21'd0, cx_mag, 11'd0};
      N_CY:    arith_num = {21'd0, cy_mag, 11'd0};
      N_SX:    arith_num = {16'd0, sx_mag, 19'd0};
      N_SY:    arith_num = {16'd0, sy_mag, 19'd0};
      default: arith_num = 52'd0;
    endcase
    case (uc.den_sel)
      D_LEN:   arith_den = len_r;
      D_R:     arith_den = {10'd0, r16};
      default: arith_den = 26'd0;
    endcase
  end

  always_comb begin
    case (uc.cond)
      C_NONE:     jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NOT_MOVE: jump = (op_r != OP_MOVE);
      C_NO_CLAMP: jump = !clamp;
      default:    jump = 1'b0;
    endcase
  end

  assign stall = (uc.hold_busy && arith_sts.busy) ||
                 ((uc.act == A_OUT) && out_valid_r && !out_ready);
  assign advance = running_r && !stall;

  assign arith_cmd.start     = advance && uc.start;
  assign arith_cmd.sqrt_mode = uc.sqrt_mode;

  vjam_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (arith_cmd),
    .num   (arith_num),
    .den   (arith_den),
    .sts   (arith_sts),
    .q     (arith_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      pc_r        <= 5'd0;
      out_valid_r <= 1'b0;
      center_x_r  <= 15'd0;
      center_y_r  <= 15'd0;
      radius_r    <= 16'd16;
      deadzone_r  <= 16'd3277;
      knob_x_r    <= 16'sd0;
      knob_y_r    <= 16'sd0;
      grab_x_r    <= 17'sd0;
      grab_y_r    <= 17'sd0;
      axis_x_r    <= 17'sd0;
      axis_y_r    <= 17'sd0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_CENTER_X: center_x_r <= cfg_data[14:0];
          REG_CENTER_Y: center_y_r <= cfg_data[14:0];
          REG_RADIUS:   radius_r   <= cfg_data;
          REG_DEADZONE: deadzone_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        running_r <= 1'b1;
        pc_r      <= 5'd0;
      end else if (advance) begin
        if (uc.last) begin
          running_r <= 1'b0;
        end
        pc_r <= jump ? uc.target : pc_r + 5'd1;
      end
      if (advance && (uc.act == A_OUT)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        case (uc.act)
          A_AX: axis_x_r <= sx_r[17] ? (17'd0 - q17) : q17;
          A_AY: axis_y_r <= sy_r[17] ? (17'd0 - q17) : q17;
          A_KNOB_CLAMP: begin
            knob_x_r <= sat_s16({{2{kx_clamp[16]}}, kx_clamp});
            knob_y_r <= sat_s16({{2{ky_clamp[16]}}, ky_clamp});
          end
          A_KNOB_DIRECT: begin
            knob_x_r <= sat_s16({px_x[17], px_x});
            knob_y_r <= sat_s16({px_y[17], px_y});
          end
          A_SIMPLE: begin
            case (op_r)
              OP_BEGIN: begin
                grab_x_r <= {knob_x_r[15], knob_x_r} - {tx_r[15], tx_r};
                grab_y_r <= {knob_y_r[15], knob_y_r} - {ty_r[15], ty_r};
              end
              OP_END: begin
                knob_x_r <= {1'b0, center_x_r};
                knob_y_r <= {1'b0, center_y_r};
                axis_x_r <= 17'sd0;
                axis_y_r <= 17'sd0;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= in_operation;
      tx_r <= in_touch_x;
      ty_r <= in_touch_y;
    end
    prod_r <= 34'(mul_a_op) * 34'(mul_b_op);
    if (advance) begin
      case (uc.act)
        A_SUM: begin
          sx_r <= sx_calc;
          sy_r <= sy_calc;
        end
        A_SQ_SET: sq_r  <= {1'b0, prod_r};
        A_SQ_ADD: sq_r  <= sq_r + {1'b0, prod_r};
        A_RSQ:    rsq_r <= prod_r[31:0];
        A_PXR:    pxr_r <= prod_r[32:0];
        A_PYR:    pyr_r <= prod_r[32:0];
        A_LEN:    len_r <= arith_q;
        A_CX:     cx_r  <= sx_r[17] ? (21'd0 - q21) : q21;
        A_CY:     cy_r  <= sy_r[17] ? (21'd0 - q21) : q21;
        A_OUT: begin
          out_knob_x_r <= knob_x_r;
          out_knob_y_r <= knob_y_r;
          out_axis_x_r <= axis_x_r;
          out_axis_y_r <= axis_y_r;
          out_dir_x_r  <= axis_dir(axis_x_r, deadzone_r);
          out_dir_y_r  <= axis_dir(axis_y_r, deadzone_r);
        end
        default: ;
      endcase
    end
  end

  assign in_ready                = !running_r;
  assign out_valid               = out_valid_r;
  assign out_knob_x              = out_knob_x_r;
  assign out_knob_y              = out_knob_y_r;
  assign out_axis_x              = out_axis_x_r;
  assign out_axis_y              = out_axis_y_r;
  assign out_left_on             = out_dir_x_r.neg;
  assign out_right_on            = out_dir_x_r.pos;
  assign out_forward_on          = out_dir_y_r.neg;
  assign out_back_on             = out_dir_y_r.pos;
  assign out_horizontal_strength = out_dir_x_r.strength;
  assign out_vertical_strength   = out_dir_y_r.strength;

endmodule

// ===== rtl/vjam_checker.sv =====
`include "virtual_joystick_axis_mapper_macros.svh"

module vjam_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_knob_x,
  input logic signed [16:0] out_axis_x,
  input logic signed [16:0] out_axis_y,
  input logic               out_left_on,
  input logic               out_right_on,
  input logic               out_forward_on,
  input logic               out_back_on,
  input logic [15:0]        out_horizontal_strength
);

  // A stalled result transaction keeps its payload.
  `VJAM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_knob_x) && $stable(out_axis_x) && $stable(out_horizontal_strength), "stalled result changed")

  // The block works on one input transaction at a time.
  `VJAM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while busy")

  // The left flag needs a negative horizontal axis and excludes the right flag.
  `VJAM_ASSERT_SAME(a_left_sign, out_valid && out_left_on, out_axis_x[16] && !out_right_on, "left flag without negative axis")

  // The forward flag needs a negative vertical axis and excludes the back flag.
  `VJAM_ASSERT_SAME(a_forward_sign, out_valid && out_forward_on, out_axis_y[16] && !out_back_on, "forward flag without negative axis")

endmodule

bind virtual_joystick_axis_mapper vjam_checker u_vjam_checker (.*);

// ===== tb/sv/stick_result_checker.sv =====
module stick_result_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic signed [15:0] in_touch_x,
  input  logic signed [15:0] in_touch_y,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_knob_x,
  input  logic signed [15:0] out_knob_y,
  input  logic signed [16:0] out_axis_x,
  input  logic signed [16:0] out_axis_y,
  input  logic               out_left_on,
  input  logic               out_right_on,
  input  logic               out_forward_on,
  input  logic               out_back_on,
  input  logic [15:0]        out_horizontal_strength,
  input  logic [15:0]        out_vertical_strength,
  input  logic               cfg_write_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 open_count
);
  import vjam_pkg::*;

  typedef struct {
    logic signed [15:0] knob_x;
    logic signed [15:0] knob_y;
    logic signed [16:0] axis_x;
    logic signed [16:0] axis_y;
    logic               left_on;
    logic               right_on;
    logic               forward_on;
    logic               back_on;
    logic [15:0]        horizontal_strength;
    logic [15:0]        vertical_strength;
  } stick_state_t;

  longint       rest_x;
  longint       rest_y;
  longint       travel_radius;
  longint       dead_band;
  longint       knob_px;
  longint       knob_py;
  longint       grab_dx;
  longint       grab_dy;
  longint       axis_hx;
  longint       axis_hy;
  stick_state_t expected_sticks[$];
  stick_state_t want;

  function automatic longint int_sqrt(input longint n);
    longint root;
    longint probe;
    root = 0;
    for (int b = 30; b >= 0; b--) begin
      probe = root | (longint'(1) << b);
      if (probe * probe <= n) begin
        root = probe;
      end
    end
    return root;
  endfunction

  function automatic longint clip16(input longint v);
    if (v > 32767) begin
      return 32767;
    end else if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  task automatic axis_flags(input longint axis, output logic neg, output logic pos,
                            output logic [15:0] strength);
    longint mag;
    mag = (axis < 0) ? -axis : axis;
    if (mag < dead_band) begin
      neg = 1'b0;
      pos = 1'b0;
      strength = '0;
    end else begin
      neg = (axis < 0);
      pos = (axis > 0);
      strength = mag[15:0];
    end
  endtask

  task automatic predict_event(input logic [1:0] op, input logic signed [15:0] tx,
                               input logic signed [15:0] ty);
    stick_state_t r;
    longint       r16;
    longint       px;
    longint       py;
    longint       sx;
    longint       sy;
    longint       sq;
    longint       len;
    longint       cx;
    longint       cy;
    if (op == OP_BEGIN) begin
      grab_dx = knob_px - longint'(tx);
      grab_dy = knob_py - longint'(ty);
    end else if (op == OP_MOVE) begin
      // A zero radius behaves as one sixteenth of a pixel.
      r16 = (travel_radius == 0) ? 1 : travel_radius;
      px = longint'(tx) + grab_dx;
      py = longint'(ty) + grab_dy;
      sx = px - rest_x;
      sy = py - rest_y;
      sq = sx * sx + sy * sy;
      if (sq * 256 > r16 * r16) begin
        len = int_sqrt(sq << 16);
        cx = sx * r16 * 4096 / len;
        cy = sy * r16 * 4096 / len;
        knob_px = clip16((rest_x * 256 + cx) / 256);
        knob_py = clip16((rest_y * 256 + cy) / 256);
        axis_hx = cx * 2048 / r16;
        axis_hy = cy * 2048 / r16;
      end else begin
        knob_px = clip16(px);
        knob_py = clip16(py);
        axis_hx = sx * 524288 / r16;
        axis_hy = sy * 524288 / r16;
      end
    end else if (op == OP_END) begin
      knob_px = rest_x;
      knob_py = rest_y;
      axis_hx = 0;
      axis_hy = 0;
    end
    r.knob_x = knob_px[15:0];
    r.knob_y = knob_py[15:0];
    r.axis_x = axis_hx[16:0];
    r.axis_y = axis_hy[16:0];
    axis_flags(axis_hx, r.left_on, r.right_on, r.horizontal_strength);
    axis_flags(axis_hy, r.forward_on, r.back_on, r.vertical_strength);
    expected_sticks.push_back(r);
  endtask

  task automatic check_field(input string name, input longint exp_val, input longint act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rest_x = 0;
      rest_y = 0;
      travel_radius = 16;
      dead_band = 3277;
      knob_px = 0;
      knob_py = 0;
      grab_dx = 0;
      grab_dy = 0;
      axis_hx = 0;
      axis_hy = 0;
      fail_count = 0;
      expected_sticks.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_sticks.size() == 0) begin
          $error("result transaction with no event pending");
          fail_count++;
        end else begin
          want = expected_sticks.pop_front();
          check_field("knob_x", want.knob_x, out_knob_x);
          check_field("knob_y", want.knob_y, out_knob_y);
          check_field("axis_x", want.axis_x, out_axis_x);
          check_field("axis_y", want.axis_y, out_axis_y);
          check_field("left_on", want.left_on, out_left_on);
          check_field("right_on", want.right_on, out_right_on);
          check_field("forward_on", want.forward_on, out_forward_on);
          check_field("back_on", want.back_on, out_back_on);
          check_field("horizontal_strength", want.horizontal_strength,
                      out_horizontal_strength);
          check_field("vertical_strength", want.vertical_strength, out_vertical_strength);
        end
      end
      if (in_valid && in_ready) begin
        predict_event(in_operation, in_touch_x, in_touch_y);
      end
      if (cfg_write_en) begin
        case (cfg_index)
          REG_CENTER_X: rest_x = cfg_data[14:0];
          REG_CENTER_Y: rest_y = cfg_data[14:0];
          REG_RADIUS:   travel_radius = cfg_data;
          REG_DEADZONE: dead_band = cfg_data;
          default: ;
        endcase
      end
    end
    open_count = expected_sticks.size();
  end

endmodule

// ===== tb/sv/tb_virtual_joystick_axis_mapper.sv =====
module tb_virtual_joystick_axis_mapper;
  import vjam_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_operation = OP_BEGIN;
  logic signed [15:0] in_touch_x = '0;
  logic signed [15:0] in_touch_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_knob_x;
  logic signed [15:0] out_knob_y;
  logic signed [16:0] out_axis_x;
  logic signed [16:0] out_axis_y;
  logic               out_left_on;
  logic               out_right_on;
  logic               out_forward_on;
  logic               out_back_on;
  logic [15:0]        out_horizontal_strength;
  logic [15:0]        out_vertical_strength;
  logic               cfg_write_en = 1'b0;
  logic [1:0]         cfg_index = REG_CENTER_X;
  logic [15:0]        cfg_data = '0;

  int  fail_count;
  int  open_count;
  int  sent = 0;
  int  received = 0;
  int  cycles = 0;
  bit  calm = 1'b0;
  int  rest_x_now = 0;
  int  rest_y_now = 0;
  int  radius_now = 16;

  virtual_joystick_axis_mapper u_top (.*);

  stick_result_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (out_valid && out_ready) begin
      received <= received + 1;
    end
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  function automatic logic signed [15:0] fit16(input int v);
    if (v > 32767) begin
      return 16'sh7FFF;
    end else if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic int near(input int base, input int span);
    return base + int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int any16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic send_event(input logic [1:0] op, input int x, input int y);
    int gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_operation = op;
    in_touch_x = fit16(x);
    in_touch_y = fit16(y);
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_index = idx;
    cfg_data = value[15:0];
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  task automatic load_setup(input int cx, input int cy, input int rad, input int dz);
    @(negedge clk);
    in_valid = 1'b0;
    wait (received >= sent);
    repeat (4) @(negedge clk);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_DEADZONE, dz);
    rest_x_now = cx;
    rest_y_now = cy;
    radius_now = rad;
  endtask

  task automatic pick_setup();
    int cx;
    int cy;
    int rad;
    int dz;
    case ($urandom_range(0, 2))
      0: cx = 0;
      1: cx = 32767;
      default: cx = $urandom_range(0, 32767);
    endcase
    case ($urandom_range(0, 2))
      0: cy = 0;
      1: cy = 32767;
      default: cy = $urandom_range(0, 32767);
    endcase
    case ($urandom_range(0, 7))
      0: rad = 1;
      1: rad = 65535;
      2: rad = 0;
      3: rad = $urandom_range(1, 65535);
      default: rad = $urandom_range(16, 4800);
    endcase
    case ($urandom_range(0, 4))
      0: dz = 0;
      1: dz = 32768;
      default: dz = $urandom_range(0, 32768);
    endcase
    load_setup(cx, cy, rad, dz);
  endtask

  task automatic run_drag();
    int span;
    int bx;
    int by;
    span = 2 * (radius_now / 16) + 4;
    if ($urandom_range(0, 3) != 0) begin
      bx = near(rest_x_now, span);
      by = near(rest_y_now, span);
    end else begin
      bx = any16();
      by = any16();
    end
    send_event(OP_BEGIN, bx, by);
    repeat ($urandom_range(1, 8)) begin
      send_event(OP_MOVE, near(bx, span), near(by, span));
    end
    if ($urandom_range(0, 4) != 0) begin
      send_event(OP_END, any16(), any16());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Moves at the reset settings, before any drag has begun.
    send_event(OP_MOVE, 0, 0);
    send_event(OP_MOVE, 5, -3);

    load_setup(100, 200, 640, 3277);
    send_event(OP_END, 0, 0);
    send_event(OP_BEGIN, 100, 200);
    send_event(OP_MOVE, 130, 200);
    send_event(OP_MOVE, 100, 160);
    send_event(OP_MOVE, 60, 200);
    send_event(OP_MOVE, 101, 200);
    send_event(OP_MOVE, -32768, -32768);
    send_event(OP_MOVE, 32767, 32767);
    send_event(OP_MOVE, 32767, -32768);
    send_event(OP_BEGIN, -32768, 32767);
    send_event(OP_MOVE, 32767, -32768);
    send_event(2'd3, 1234, -1234);
    send_event(OP_END, 0, 0);

    // Largest center and radius push the knob past the 16-bit range.
    load_setup(32767, 32767, 65535, 32768);
    send_event(OP_END, 0, 0);
    send_event(OP_BEGIN, 0, 0);
    send_event(OP_MOVE, 4096, 0);
    send_event(OP_MOVE, 2000, 1000);
    send_event(OP_MOVE, -32768, -32768);
    send_event(OP_END, 0, 0);

    load_setup(0, 0, 0, 0);
    send_event(OP_END, 0, 0);
    send_event(OP_MOVE, 0, 0);
    send_event(OP_MOVE, 1, 0);
    send_event(OP_MOVE, 0, -1);

    for (int ph = 0; ph < 8; ph++) begin
      pick_setup();
      calm = (ph == 7);
      while (sent < 25 + 150 * (ph + 1)) begin
        if ($urandom_range(0, 9) < 8) begin
          run_drag();
        end else begin
          send_event(2'($urandom_range(0, 3)), any16(), any16());
        end
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait (received >= sent);
    repeat (140) @(posedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
